>>> rtl/tsv_pkg.sv
// ============================================================================
// tsv_pkg
// Shared types and constants for the TCP segment validator: verdict codes,
// header byte offsets and the beat and status structs passed between stages.
// ============================================================================
package tsv_pkg;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS         = 2'd0;
    localparam logic [1:0] VERDICT_NOT_TCP      = 2'd1;
    localparam logic [1:0] VERDICT_BAD_LENGTH   = 2'd2;
    localparam logic [1:0] VERDICT_BAD_CHECKSUM = 2'd3;

    localparam logic [7:0] TCP_PROTOCOL_NUM = 8'd6;

    // Byte counter saturates at its all-ones value
    localparam int unsigned  BYTE_CNT_BITS  = 17;
    localparam logic [16:0]  BYTE_COUNT_MAX = '1;

    // IPv4 header byte offsets
    localparam logic [16:0] OFF_TOT_LEN_HI = 17'd2;
    localparam logic [16:0] OFF_TOT_LEN_LO = 17'd3;
    localparam logic [16:0] OFF_PROTOCOL   = 17'd9;
    localparam logic [16:0] OFF_ADDR_FIRST = 17'd12;
    localparam logic [16:0] OFF_ADDR_END   = 17'd20;
    // TCP data offset byte, relative to the start of the segment
    localparam logic [16:0] OFF_TCP_DOFF   = 17'd12;

    // Length limits
    localparam logic [16:0] MIN_PROTO_LEN = 17'd10;
    localparam logic [5:0]  MIN_IP_HDR    = 6'd20;
    localparam logic [5:0]  MIN_TCP_HDR   = 6'd20;

    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

    typedef logic [1:0] t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       no_net_header;
    } t_beat;

    // Per-packet status from the tracker to the result stage
    typedef struct packed {
        logic     done;
        t_verdict verdict;
    } t_pkt_status;

endpackage

>>> rtl/tsv_ifs.sv
// ============================================================================
// tsv_ifs
// Valid/ready channels of the TCP segment validator: packet bytes in,
// verdicts with drop counter values out.
// ============================================================================
interface tsv_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_net_header;

    modport source (output valid, data_byte, last_byte, no_net_header, input ready);
    modport sink   (input valid, data_byte, last_byte, no_net_header, output ready);
endinterface

interface tsv_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] drop_total;
    logic [31:0] drop_not_tcp;
    logic [31:0] drop_bad_length;
    logic [31:0] drop_bad_checksum;

    modport source (output valid, verdict, drop_total, drop_not_tcp, drop_bad_length,
                    drop_bad_checksum, input ready);
    modport sink   (input valid, verdict, drop_total, drop_not_tcp, drop_bad_length,
                    drop_bad_checksum, output ready);
    modport monitor (input valid, ready, verdict, drop_total, drop_not_tcp,
                     drop_bad_length, drop_bad_checksum);
endinterface

>>> rtl/tsv_ingress.sv
// ============================================================================
// tsv_ingress
// Input register for packet bytes. Holds one beat and releases it to the
// tracker when the result stage can take whatever that beat produces.
// ============================================================================
module tsv_ingress (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsv_pkt_if.sink       i_pkt,
    input  logic          i_out_free,
    output tsv_pkg::t_beat o_beat,
    output logic          o_advance
);
    import tsv_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_beat r_beat;
    logic  w_proc;
    logic  w_accept;

    // A last byte needs a free result slot; other bytes always move on
    assign w_proc      = r_valid && (!r_beat.last_byte || i_out_free);
    assign i_pkt.ready = !r_valid || w_proc;
    assign w_accept    = i_pkt.valid && i_pkt.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_proc) begin
            n_valid = 1'b0;
        end
    end

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture beat payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_beat.data_byte     <= i_pkt.data_byte;
            r_beat.last_byte     <= i_pkt.last_byte;
            r_beat.no_net_header <= i_pkt.no_net_header;
        end
    end

    assign o_beat    = r_beat;
    assign o_advance = w_proc;

endmodule

>>> rtl/tsv_tracker.sv
// ============================================================================
// tsv_tracker
// Per-packet state: byte count, captured header fields and the folded
// ones'-complement sum. Forms the verdict on the last byte of a packet.
// ============================================================================
module tsv_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsv_pkg::t_beat      i_beat,
    input  logic                i_advance,
    output tsv_pkg::t_pkt_status o_status
);
    import tsv_pkg::*;

    logic [16:0] r_byte_count;
    logic [5:0]  r_ip_hdr_bytes;
    logic [15:0] r_ip_tot_len;
    logic [7:0]  r_protocol;
    logic [3:0]  r_tcp_hdr_words;
    logic [16:0] r_sum;
    logic        r_missing_hdr;

    logic [16:0] n_byte_count;
    logic [5:0]  n_ip_hdr_bytes;
    logic [15:0] n_ip_tot_len;
    logic [7:0]  n_protocol;
    logic [3:0]  n_tcp_hdr_words;
    logic [16:0] n_sum;
    logic        n_missing_hdr;

    logic [7:0]  w_b;
    logic [16:0] w_i;
    logic        w_first;
    logic [16:0] w_ihl_ext;
    logic [16:0] w_seg_off;
    logic        w_in_addr;
    logic        w_in_seg;
    logic [15:0] w_word;
    logic [17:0] w_acc_raw;
    logic [5:0]  w_tcph;
    logic [15:0] w_tcp_len;
    logic [17:0] w_chk_raw;
    logic [16:0] w_chk_fold1;
    logic [15:0] w_chk_fold2;
    t_verdict    w_verdict;

    assign w_b       = i_beat.data_byte;
    assign w_i       = r_byte_count;
    assign w_first   = (w_i == '0);
    assign w_ihl_ext = {11'b0, r_ip_hdr_bytes};
    assign w_seg_off = w_i - w_ihl_ext;

    // Address bytes of the IP header, then the TCP segment up to the total length
    assign w_in_addr = (w_i >= OFF_ADDR_FIRST) && (w_i < OFF_ADDR_END);
    assign w_in_seg  = (r_ip_hdr_bytes >= MIN_IP_HDR) && (w_i >= w_ihl_ext) &&
                       (w_i < {1'b0, r_ip_tot_len});

    // Even bytes land high in the 16-bit word; header length is a multiple of 4
    assign w_word    = w_i[0] ? {8'b0, w_b} : {w_b, 8'b0};
    assign w_acc_raw = {1'b0, r_sum} + {2'b0, w_word};

    // Next per-packet state for this byte
    always_comb begin
        n_byte_count    = (w_i == BYTE_COUNT_MAX) ? w_i : w_i + 17'd1;
        n_ip_hdr_bytes  = r_ip_hdr_bytes;
        n_ip_tot_len    = r_ip_tot_len;
        n_protocol      = r_protocol;
        n_tcp_hdr_words = r_tcp_hdr_words;
        n_sum           = r_sum;
        n_missing_hdr   = r_missing_hdr;
        if (w_first) begin
            n_missing_hdr  = i_beat.no_net_header;
            n_ip_hdr_bytes = {w_b[3:0], 2'b00};
        end
        if (w_i == OFF_TOT_LEN_HI) begin
            n_ip_tot_len[15:8] = w_b;
        end
        if (w_i == OFF_TOT_LEN_LO) begin
            n_ip_tot_len[7:0] = w_b;
        end
        if (w_i == OFF_PROTOCOL) begin
            n_protocol = w_b;
        end
        if (w_in_seg && (w_seg_off == OFF_TCP_DOFF)) begin
            n_tcp_hdr_words = w_b[7:4];
        end
        if (w_in_addr || w_in_seg) begin
            n_sum = {1'b0, w_acc_raw[15:0]} + {15'b0, w_acc_raw[17:16]};
        end
    end

    // Close the pseudo-header sum with protocol and TCP length
    assign w_tcph      = {n_tcp_hdr_words, 2'b00};
    assign w_tcp_len   = n_ip_tot_len - {10'b0, n_ip_hdr_bytes};
    assign w_chk_raw   = {1'b0, n_sum} + {10'b0, TCP_PROTOCOL_NUM} + {2'b0, w_tcp_len};
    assign w_chk_fold1 = {1'b0, w_chk_raw[15:0]} + {15'b0, w_chk_raw[17:16]};
    assign w_chk_fold2 = w_chk_fold1[15:0] + {15'b0, w_chk_fold1[16]};

    // Pick the verdict in priority order
    always_comb begin
        if (n_missing_hdr) begin
            w_verdict = VERDICT_NOT_TCP;
        end else if (n_byte_count < MIN_PROTO_LEN) begin
            w_verdict = VERDICT_BAD_LENGTH;
        end else if (n_protocol != TCP_PROTOCOL_NUM) begin
            w_verdict = VERDICT_NOT_TCP;
        end else if ((n_ip_hdr_bytes < MIN_IP_HDR) ||
                     (n_ip_tot_len < {10'b0, n_ip_hdr_bytes}) ||
                     (w_tcph < MIN_TCP_HDR) ||
                     (w_tcp_len < {10'b0, w_tcph}) ||
                     (n_byte_count < {1'b0, n_ip_tot_len})) begin
            w_verdict = VERDICT_BAD_LENGTH;
        end else if (w_chk_fold2 == SUM_ALL_ONES) begin
            w_verdict = VERDICT_PASS;
        end else begin
            w_verdict = VERDICT_BAD_CHECKSUM;
        end
    end

    // Advance state; drop it all at the end of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_beat.last_byte)) begin
            r_byte_count    <= '0;
            r_ip_hdr_bytes  <= '0;
            r_ip_tot_len    <= '0;
            r_protocol      <= '0;
            r_tcp_hdr_words <= '0;
            r_sum           <= '0;
            r_missing_hdr   <= 1'b0;
        end else if (i_advance) begin
            r_byte_count    <= n_byte_count;
            r_ip_hdr_bytes  <= n_ip_hdr_bytes;
            r_ip_tot_len    <= n_ip_tot_len;
            r_protocol      <= n_protocol;
            r_tcp_hdr_words <= n_tcp_hdr_words;
            r_sum           <= n_sum;
            r_missing_hdr   <= n_missing_hdr;
        end
    end

    assign o_status.done    = i_advance && i_beat.last_byte;
    assign o_status.verdict = w_verdict;

endmodule

>>> rtl/tsv_result.sv
// ============================================================================
// tsv_result
// Drop counters, the details register and the output register that holds
// one verdict beat until the sink takes it.
// ============================================================================
module tsv_result #(
    parameter int unsigned COUNTER_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  tsv_pkg::t_pkt_status i_status,
    output logic                 o_out_free,
    tsv_res_if.source            o_res
);
    import tsv_pkg::*;

    localparam int unsigned EXT_BITS = COUNTER_BITS + 32;

    logic                    r_count_details;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_verdict                r_verdict;
    logic [COUNTER_BITS-1:0] r_drop_total;
    logic [COUNTER_BITS-1:0] r_drop_not_tcp;
    logic [COUNTER_BITS-1:0] r_drop_bad_len;
    logic [COUNTER_BITS-1:0] r_drop_bad_chk;
    logic                    w_drop;
    logic [EXT_BITS-1:0]     w_total_ext;
    logic [EXT_BITS-1:0]     w_not_tcp_ext;
    logic [EXT_BITS-1:0]     w_bad_len_ext;
    logic [EXT_BITS-1:0]     w_bad_chk_ext;

    assign o_out_free = !r_out_valid || o_res.ready;
    assign w_drop     = i_status.done && (i_status.verdict != VERDICT_PASS);

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_status.done) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Details register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_details <= 1'b0;
        end else if (i_cfg_we) begin
            r_count_details <= i_cfg_wdata;
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the verdict with its beat
    always_ff @(posedge i_clk) begin
        if (i_status.done) begin
            r_verdict <= i_status.verdict;
        end
    end

    // Count drops; per-reason counters only with details on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_total   <= '0;
            r_drop_not_tcp <= '0;
            r_drop_bad_len <= '0;
            r_drop_bad_chk <= '0;
        end else if (w_drop) begin
            r_drop_total <= r_drop_total + COUNTER_BITS'(1);
            if (r_count_details) begin
                unique case (i_status.verdict)
                    VERDICT_NOT_TCP:    r_drop_not_tcp <= r_drop_not_tcp + COUNTER_BITS'(1);
                    VERDICT_BAD_LENGTH: r_drop_bad_len <= r_drop_bad_len + COUNTER_BITS'(1);
                    VERDICT_BAD_CHECKSUM: begin
                        r_drop_bad_chk <= r_drop_bad_chk + COUNTER_BITS'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Counters only move with a new beat, so they stand in for its payload
    assign w_total_ext   = EXT_BITS'(r_drop_total);
    assign w_not_tcp_ext = EXT_BITS'(r_drop_not_tcp);
    assign w_bad_len_ext = EXT_BITS'(r_drop_bad_len);
    assign w_bad_chk_ext = EXT_BITS'(r_drop_bad_chk);

    assign o_res.valid             = r_out_valid;
    assign o_res.verdict           = r_verdict;
    assign o_res.drop_total        = w_total_ext[31:0];
    assign o_res.drop_not_tcp      = w_not_tcp_ext[31:0];
    assign o_res.drop_bad_length   = w_bad_len_ext[31:0];
    assign o_res.drop_bad_checksum = w_bad_chk_ext[31:0];

endmodule

>>> rtl/tcp_segment_validator.sv
// ============================================================================
// tcp_segment_validator
// Checks TCP length fields and the TCP checksum of IPv4 packets streamed
// one byte per beat, and keeps wrapping drop counters.
// ============================================================================
// Takes one packet byte per clock, starting at IPv4 header byte 0, and gives
// one verdict beat per packet (pass, not TCP, bad length, bad checksum) with
// the drop counter values after that packet. A byte passes through an input
// register, then one level of header capture, checksum fold and verdict
// logic, then the output register, so a new byte is taken every cycle; the
// input stalls only when a last byte meets a verdict the sink has not yet
// taken. The per-reason counters count only while count_details is set;
// drop_total always counts. Change count_details only between packets.
module tcp_segment_validator #(
    parameter int unsigned COUNTER_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    tsv_pkt_if.sink   i_pkt,
    tsv_res_if.source o_res
);
    import tsv_pkg::*;

    t_beat       w_beat;
    logic        w_advance;
    logic        w_out_free;
    t_pkt_status w_status;

    tsv_ingress u_ingress (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (i_pkt),
        .i_out_free (w_out_free),
        .o_beat     (w_beat),
        .o_advance  (w_advance)
    );

    tsv_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (w_beat),
        .i_advance (w_advance),
        .o_status  (w_status)
    );

    tsv_result #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (w_status),
        .o_out_free  (w_out_free),
        .o_res       (o_res)
    );

endmodule

>>> rtl/tsv_checker.sv
// ============================================================================
// tsv_checker
// Port-level checks on the validator: output beat holding and the way the
// drop counters move with each verdict.
// ============================================================================
module tsv_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  tsv_pkg::t_verdict i_res_verdict,
    input  logic [31:0]       i_drop_total,
    input  logic [31:0]       i_drop_not_tcp
);
    import tsv_pkg::*;

    // Stalled output beat holds its verdict
    a_hold_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_verdict)))
        else $error("output beat dropped or changed while stalled");

    // Total only moves together with a shown verdict
    a_total_with_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (i_drop_total != $past(i_drop_total))) |-> i_res_valid)
        else $error("drop_total moved without a verdict beat");

    // A fresh pass leaves the total alone
    a_pass_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(i_res_valid) && (i_res_verdict == VERDICT_PASS))
        |-> (i_drop_total == $past(i_drop_total)))
        else $error("drop_total moved on a pass");

    // A fresh drop bumps the total by one
    a_drop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(i_res_valid) && (i_res_verdict != VERDICT_PASS))
        |-> (i_drop_total == ($past(i_drop_total) + 32'd1)))
        else $error("drop_total did not advance on a drop");

    // The not-TCP counter moves only for a not-TCP verdict
    a_not_tcp_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (i_drop_not_tcp != $past(i_drop_not_tcp)))
        |-> (i_res_valid && (i_res_verdict == VERDICT_NOT_TCP)))
        else $error("drop_not_tcp moved for another verdict");

endmodule

bind tcp_segment_validator tsv_checker u_tsv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_verdict  (o_res.verdict),
    .i_drop_total   (o_res.drop_total),
    .i_drop_not_tcp (o_res.drop_not_tcp)
);
